// ===== src/line_rasterizer_top_macros.svh =====
// Assertion macros shared by the line rasterizer checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef LINE_RASTERIZER_TOP_MACROS_SVH
`define LINE_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while the given reset term is high.
`define LRAST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the given reset term is high.
`define LRAST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lrast_pkg.sv =====
// Package for the line rasterizer: payload structs, codes and default widths.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lrast_pkg;

  // Fixed width of every coordinate and color field on the ports.
  localparam int FIELD_W = 16;

  // Default number of coordinate bits that the block actually uses.
  localparam int COORD_BITS_DEF = 16;

  // Command codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Step direction codes on one axis.
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_PLUS  = 2'd1;
  localparam logic [1:0] DIR_MINUS = 2'd3;

  // One command item.
  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] x_start;
    logic [FIELD_W-1:0] y_start;
    logic [FIELD_W-1:0] x_end;
    logic [FIELD_W-1:0] y_end;
    logic [FIELD_W-1:0] line_color;
  } lrast_cmd_t;

  // One pixel item.
  typedef struct packed {
    logic [FIELD_W-1:0] pixel_x;
    logic [FIELD_W-1:0] pixel_y;
    logic [FIELD_W-1:0] pixel_color;
    logic               last_pixel;
  } lrast_pix_t;

endpackage

// ===== src/lrast_axis.sv =====
// Per-axis line setup: absolute delta and step direction between two endpoints.
// Depends on lrast_pkg for the direction codes.
`timescale 1ns / 1ps

module lrast_axis #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0] pos_a,
  input  logic [COORD_BITS-1:0] pos_b,
  output logic [COORD_BITS-1:0] mag,
  output logic [1:0]            dir
);

  // Comparisons pick the direction, one subtract gives the magnitude.
  always_comb begin
    if (pos_b > pos_a) begin
      mag = pos_b - pos_a;
      dir = lrast_pkg::DIR_PLUS;
    end else if (pos_b == pos_a) begin
      mag = '0;
      dir = lrast_pkg::DIR_NONE;
    end else begin
      mag = pos_a - pos_b;
      dir = lrast_pkg::DIR_MINUS;
    end
  end

endmodule

// ===== src/lrast_stepper.sv =====
// Line state and one Bresenham step per command: setup on start, one pixel per step.
// Depends on lrast_pkg and lrast_axis.
`timescale 1ns / 1ps

module lrast_stepper #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  lrast_pkg::lrast_cmd_t  cmd,
  output logic                   pix_vld,
  output lrast_pkg::lrast_pix_t  pix
);

  localparam int CB = COORD_BITS;
  localparam int EB = COORD_BITS + 1;
  localparam int FW = lrast_pkg::FIELD_W;

  // Line state.
  logic          active;
  logic [CB-1:0] cur_col;
  logic [CB-1:0] cur_row;
  logic [EB-1:0] err_col;
  logic [EB-1:0] err_row;
  logic [CB-1:0] abs_dcol;
  logic [CB-1:0] abs_drow;
  logic [1:0]    dir_col;
  logic [1:0]    dir_row;
  logic [CB-1:0] major_len;
  logic [EB-1:0] pixels_left;
  logic [FW-1:0] held_color;

  // Setup values for a new line.
  logic [CB-1:0] xs, ys, xe, ye;
  logic [CB-1:0] dcol_new, drow_new, major_new;
  logic [1:0]    dir_col_new, dir_row_new;
  logic          is_start;

  // Step values.
  logic [EB-1:0] major_e;
  logic [EB-1:0] sum_col, sum_row;
  logic          move_col, move_row;
  logic [EB-1:0] err_col_next, err_row_next;
  logic [CB-1:0] cur_col_next, cur_row_next;

  // Move a position one pixel in the given direction, wrapping at the coordinate width.
  function automatic logic [CB-1:0] step_pos(input logic [CB-1:0] pos, input logic [1:0] dir);
    logic [CB-1:0] res;
    case (dir)
      lrast_pkg::DIR_PLUS:  res = pos + CB'(1);
      lrast_pkg::DIR_MINUS: res = pos - CB'(1);
      default:              res = pos;
    endcase
    return res;
  endfunction

  assign is_start = (cmd.operation == lrast_pkg::OP_START);
  assign xs = cmd.x_start[CB-1:0];
  assign ys = cmd.y_start[CB-1:0];
  assign xe = cmd.x_end[CB-1:0];
  assign ye = cmd.y_end[CB-1:0];

  // Per-axis deltas and directions of the new line.
  lrast_axis #(.COORD_BITS(COORD_BITS)) u_axis_col (
    .pos_a (xs),
    .pos_b (xe),
    .mag   (dcol_new),
    .dir   (dir_col_new)
  );

  lrast_axis #(.COORD_BITS(COORD_BITS)) u_axis_row (
    .pos_a (ys),
    .pos_b (ye),
    .mag   (drow_new),
    .dir   (dir_row_new)
  );

  assign major_new = (dcol_new > drow_new) ? dcol_new : drow_new;

  // Error update: add the delta, and step the axis once the error passes the major length.
  // The error never exceeds twice the major length, so one extra bit holds it.
  always_comb begin
    major_e      = EB'(major_len);
    sum_col      = err_col + EB'(abs_dcol);
    sum_row      = err_row + EB'(abs_drow);
    move_col     = (sum_col > major_e);
    move_row     = (sum_row > major_e);
    err_col_next = move_col ? (sum_col - major_e) : sum_col;
    err_row_next = move_row ? (sum_row - major_e) : sum_row;
    cur_col_next = move_col ? step_pos(cur_col, dir_col) : cur_col;
    cur_row_next = move_row ? step_pos(cur_row, dir_row) : cur_row;
  end

  // A step command while a line runs yields the current pixel.
  assign pix_vld = go && !is_start && active;

  always_comb begin
    pix.pixel_x     = FW'(cur_col);
    pix.pixel_y     = FW'(cur_row);
    pix.pixel_color = held_color;
    pix.last_pixel  = (pixels_left == EB'(1));
  end

  // Control state: line activity and remaining pixel count.
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pixels_left <= '0;
    end else if (go) begin
      if (is_start) begin
        active      <= 1'b1;
        pixels_left <= EB'(major_new) + EB'(2);
      end else if (active) begin
        if (pixels_left <= EB'(1)) begin
          active      <= 1'b0;
          pixels_left <= '0;
        end else begin
          pixels_left <= pixels_left - EB'(1);
        end
      end
    end
  end

  // Line geometry and walking position.
  always_ff @(posedge clk) begin
    if (go) begin
      if (is_start) begin
        cur_col    <= xs;
        cur_row    <= ys;
        err_col    <= '0;
        err_row    <= '0;
        abs_dcol   <= dcol_new;
        abs_drow   <= drow_new;
        dir_col    <= dir_col_new;
        dir_row    <= dir_row_new;
        major_len  <= major_new;
        held_color <= cmd.line_color;
      end else if (active) begin
        cur_col <= cur_col_next;
        cur_row <= cur_row_next;
        err_col <= err_col_next;
        err_row <= err_row_next;
      end
    end
  end

endmodule

// ===== src/line_rasterizer_top.sv =====
// Line rasterizer: command input register, line stepper, pixel output register.
// Depends on lrast_pkg and lrast_stepper.
// A step command passes through the command register, then the stepper, into the pixel register.
// Throughput: one command per cycle while the pixel output is not stalled, one pixel per step
// command, set by the combinational error update in the stepper; start commands produce no pixel.
// Reset (synchronous, active high) empties both registers and leaves no line active.
`timescale 1ns / 1ps

module line_rasterizer_top #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  lrast_pkg::lrast_cmd_t cmd,
  output logic                  pix_valid,
  input  logic                  pix_ready,
  output lrast_pkg::lrast_pix_t pix
);

  logic                  cmd_vld_r;
  lrast_pkg::lrast_cmd_t cmd_r;
  logic                  go;
  logic                  step_vld;
  lrast_pkg::lrast_pix_t step_pix;
  logic                  pix_vld_r;
  lrast_pkg::lrast_pix_t pix_r;

  // The held command advances whenever the pixel register is free or being drained.
  assign go        = cmd_vld_r && (!pix_vld_r || pix_ready);
  assign cmd_ready = !cmd_vld_r || go;

  // Command register: takes a new transfer whenever the held one moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld_r <= 1'b0;
    end else if (cmd_ready) begin
      cmd_vld_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready) begin
      cmd_r <= cmd;
    end
  end

  lrast_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .cmd     (cmd_r),
    .pix_vld (step_vld),
    .pix     (step_pix)
  );

  // Pixel register: loaded by each step, cleared once its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_vld_r <= 1'b0;
    end else if (step_vld) begin
      pix_vld_r <= 1'b1;
    end else if (pix_ready) begin
      pix_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_vld) begin
      pix_r <= step_pix;
    end
  end

  assign pix_valid = pix_vld_r;
  assign pix       = pix_r;

endmodule

// ===== src/lrast_checker.sv =====
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on lrast_pkg and line_rasterizer_top_macros.svh.
`timescale 1ns / 1ps
`include "line_rasterizer_top_macros.svh"

module lrast_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input lrast_pkg::lrast_cmd_t cmd,
  input logic                  pix_valid,
  input logic                  pix_ready,
  input lrast_pkg::lrast_pix_t pix
);

  // A stalled pixel stays offered and unchanged.
  `LRAST_ASSERT_NEXT(a_pix_hold, clk, rst, pix_valid && !pix_ready, pix_valid && $stable(pix), "pixel changed while stalled")

  // Reset leaves no pixel on offer.
  `LRAST_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !pix_valid, "pixel offered after reset")

  // A fresh pixel comes from a step command transferred at the input before it.
  `LRAST_ASSERT_NOW(a_pix_from_step, clk, rst, $rose(pix_valid), $past(cmd_valid && cmd_ready && (cmd.operation == lrast_pkg::OP_STEP), 2), "pixel without a step command")

endmodule

bind line_rasterizer_top lrast_checker u_lrast_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .pix_valid (pix_valid),
  .pix_ready (pix_ready),
  .pix       (pix)
);
